@@ design/assert_macros.svh @@
// Assertion helpers for the compensation core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Concurrent assertion on the rising clock edge, off while reset is low.
`define ASSERT_CLK(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");
// Same check, but also evaluated while reset is held.
`define ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk_i) (prop)) else $error("assertion failed");
`endif

@@ design/ptc_pkg.sv @@
`default_nettype none
package ptc_pkg;
  localparam int unsigned StageCount = 44;
  localparam int unsigned DivBits = 32;

  localparam logic [1:0] CfgTemp = 2'd0;
  localparam logic [1:0] CfgPressLow = 2'd1;
  localparam logic [1:0] CfgPressHigh = 2'd2;
  localparam logic [1:0] CfgPressNine = 2'd3;

  typedef struct packed {
    logic [19:0] raw_temperature;
    logic [19:0] raw_pressure;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] temperature_centi;
    logic [31:0] pressure_pa;
    logic pressure_invalid;
  } out_item_t;

  // Everything one item carries while it moves down the chain of cells.
  typedef struct packed {
    logic [31:0] x0;
    logic [31:0] x1;
    logic [31:0] x2;
    logic [31:0] x3;
    logic [31:0] temp;
    logic [19:0] up;
    logic [31:0] rem;
    logic [31:0] quo;
    logic [31:0] dvs;
    logic hi;
    logic inv;
  } work_t;

  typedef struct packed {
    logic [15:0] t1;
    logic [15:0] t2;
    logic [15:0] t3;
    logic [15:0] p1;
    logic [15:0] p2;
    logic [15:0] p3;
    logic [15:0] p4;
    logic [15:0] p5;
    logic [15:0] p6;
    logic [15:0] p7;
    logic [15:0] p8;
    logic [15:0] p9;
  } coeff_t;

  function automatic logic [31:0] sx16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] asr(input logic [31:0] x, input int unsigned n);
    return 32'($signed(x) >>> n);
  endfunction
endpackage
`default_nettype wire

@@ design/ptc_arith_cell.sv @@
`default_nettype none
// Arithmetic cell: one formula step per position, at most two 32x32 products.
module ptc_arith_cell (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 en_i,
  input  wire  [5:0]          pos_i,
  input  ptc_pkg::coeff_t     cf_i,
  input  wire                 vld_i,
  input  ptc_pkg::work_t      w_i,
  output logic                vld_o,
  output ptc_pkg::work_t      w_o
);
  import ptc_pkg::*;
  work_t w_d;
  logic [31:0] m;

  always_comb begin
    w_d = w_i;
    m = '0;
    case (pos_i)
      6'd0: begin
        // x0 = ut, x1 = d
        w_d.x1 = {16'd0, w_i.x0[19:4]} - {16'd0, cf_i.t1};
        w_d.x2 = {15'd0, w_i.x0[19:3]} - {15'd0, cf_i.t1, 1'b0};
      end
      6'd1: begin
        m = w_i.x2 * sx16(cf_i.t2);
        w_d.x2 = asr(m, 11);
        m = w_i.x1 * w_i.x1;
        w_d.x1 = asr(m, 12);
      end
      6'd2: begin
        m = w_i.x1 * sx16(cf_i.t3);
        w_d.x0 = w_i.x2 + asr(m, 14);
      end
      6'd3: begin
        m = w_i.x0 * 32'd5;
        w_d.temp = asr(m + 32'd128, 8);
        w_d.x1 = asr(w_i.x0, 1) - 32'd64000;
        w_d.x2 = asr(asr(w_i.x0, 1) - 32'd64000, 2);
      end
      6'd4: begin
        // x1 = a, x2 = q; x3 = q*q
        m = w_i.x2 * w_i.x2;
        w_d.x3 = m;
        w_d.x0 = w_i.x1 * sx16(cf_i.p5);
      end
      6'd5: begin
        m = asr(w_i.x3, 11) * sx16(cf_i.p6);
        w_d.x0 = m + {w_i.x0[30:0], 1'b0};
        w_d.x2 = w_i.x1 * sx16(cf_i.p2);
      end
      6'd6: begin
        w_d.x0 = asr(w_i.x0, 2) + {cf_i.p4, 16'd0};
        m = sx16(cf_i.p3) * asr(w_i.x3, 13);
        w_d.x1 = asr(asr(m, 3) + asr(w_i.x2, 1), 18);
      end
      6'd7: begin
        m = (32'd32768 + w_i.x1) * {16'd0, cf_i.p1};
        w_d.dvs = asr(m, 15);
        w_d.x2 = (32'd1048576 - {12'd0, w_i.up}) - asr(w_i.x0, 12);
      end
      6'd8: begin
        m = w_i.x2 * 32'd3125;
        w_d.inv = (w_i.dvs == '0);
        w_d.hi = m[31];
        w_d.rem = '0;
        w_d.quo = m[31] ? m : {m[30:0], 1'b0};
      end
      6'd41: begin
        w_d.x0 = w_i.hi ? {w_i.quo[30:0], 1'b0} : w_i.quo;
      end
      6'd42: begin
        m = {3'd0, w_i.x0[31:3]} * {3'd0, w_i.x0[31:3]};
        w_d.x1 = {13'd0, m[31:13]};
        w_d.x2 = asr({2'd0, w_i.x0[31:2]} * sx16(cf_i.p8), 13);
      end
      6'd43: begin
        m = sx16(cf_i.p9) * w_i.x1;
        w_d.x3 = w_i.inv ? '0 :
                 w_i.x0 + asr(asr(m, 12) + w_i.x2 + sx16(cf_i.p7), 4);
      end
      default: begin
        w_d = w_i;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_o <= 1'b0;
    end else if (en_i) begin
      vld_o <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      w_o <= w_d;
    end
  end
endmodule
`default_nettype wire

@@ design/ptc_div_cell.sv @@
`default_nettype none
// Restoring division cell: one quotient bit per cell.
module ptc_div_cell (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             en_i,
  input  wire             vld_i,
  input  ptc_pkg::work_t  w_i,
  output logic            vld_o,
  output ptc_pkg::work_t  w_o
);
  import ptc_pkg::*;
  work_t w_d;
  logic [32:0] trial;
  logic [32:0] shifted;

  always_comb begin
    w_d = w_i;
    shifted = {w_i.rem, w_i.quo[31]};
    trial = shifted - {1'b0, w_i.dvs};
    w_d.quo = {w_i.quo[30:0], ~trial[32]};
    w_d.rem = trial[32] ? shifted[31:0] : trial[31:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_o <= 1'b0;
    end else if (en_i) begin
      vld_o <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      w_o <= w_d;
    end
  end
endmodule
`default_nettype wire

@@ design/pressure_temperature_compensation_core.sv @@
`default_nettype none
// Compensation core: each item (raw temperature and raw pressure) runs down a
// chain of 44 cells, one cell a cycle while the chain is not held; the first
// cell loads at the edge that accepts the item. The result is a temperature in
// hundredths of a degree and a pressure in pascals. One item is accepted every
// cycle unless the output is stalled; the chain length is set mostly by the 32
// one-bit divider cells. When the output is stalled the whole chain holds, so
// nothing is lost. The user must write coefficients through the configuration
// port only while the core is idle; the core does not enforce this.
module pressure_temperature_compensation_core (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  input  ptc_pkg::in_item_t    in_data_i,
  output logic                 out_valid_o,
  input  wire                  out_ready_i,
  output ptc_pkg::out_item_t   out_data_o,
  input  wire                  cfg_valid_i,
  output logic                 cfg_ready_o,
  input  wire  [1:0]           cfg_index_i,
  input  wire  [63:0]          cfg_data_i
);
  `include "assert_macros.svh"
  import ptc_pkg::*;

  logic [47:0] temp_q;
  logic [63:0] plow_q;
  logic [63:0] phigh_q;
  logic [15:0] p9_q;
  coeff_t cf;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_q <= '0;
      plow_q <= '0;
      phigh_q <= '0;
      p9_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgTemp: temp_q <= cfg_data_i[47:0];
        CfgPressLow: plow_q <= cfg_data_i;
        CfgPressHigh: phigh_q <= cfg_data_i;
        CfgPressNine: p9_q <= cfg_data_i[15:0];
        default: temp_q <= temp_q;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;
  assign cf = '{t1: temp_q[15:0], t2: temp_q[31:16], t3: temp_q[47:32],
                p1: plow_q[15:0], p2: plow_q[31:16], p3: plow_q[47:32],
                p4: plow_q[63:48], p5: phigh_q[15:0], p6: phigh_q[31:16],
                p7: phigh_q[47:32], p8: phigh_q[63:48], p9: p9_q};

  // The chain advances whenever the last cell is empty or being drained.
  logic en;
  logic vld [StageCount+1];
  work_t w [StageCount+1];

  assign en = !vld[StageCount] || out_ready_i;
  assign in_ready_o = en;
  assign vld[0] = in_valid_i;
  always_comb begin
    w[0] = '0;
    w[0].x0 = {12'd0, in_data_i.raw_temperature};
    w[0].up = in_data_i.raw_pressure;
  end

  for (genvar g = 0; g < StageCount; g++) begin : g_cell
    if (g >= 9 && g < 9 + DivBits) begin : g_div
      ptc_div_cell u_div (
        .clk_i(clk_i), .rst_ni(rst_ni), .en_i(en),
        .vld_i(vld[g]), .w_i(w[g]), .vld_o(vld[g+1]), .w_o(w[g+1])
      );
    end else begin : g_ar
      ptc_arith_cell u_ar (
        .clk_i(clk_i), .rst_ni(rst_ni), .en_i(en), .pos_i(6'(g)), .cf_i(cf),
        .vld_i(vld[g]), .w_i(w[g]), .vld_o(vld[g+1]), .w_o(w[g+1])
      );
    end
  end

  assign out_valid_o = vld[StageCount];
  assign out_data_o.temperature_centi = w[StageCount].temp;
  assign out_data_o.pressure_pa = w[StageCount].x3;
  assign out_data_o.pressure_invalid = w[StageCount].inv;

  `ASSERT_CLK(a_stall_holds, out_valid_o && !out_ready_i |=> out_valid_o)
  `ASSERT_CLK(a_ready_follows, !out_valid_o |-> in_ready_o)
  `ASSERT_CLK(a_invalid_zero, out_valid_o && out_data_o.pressure_invalid |->
              out_data_o.pressure_pa == '0)
  `ASSERT_ALWAYS(a_reset_empty, !rst_ni |-> !out_valid_o)
endmodule
`default_nettype wire

@@ tb/ptc_checker.sv @@
module ptc_checker (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  input  wire                in_ready_i,
  input  ptc_pkg::in_item_t  in_data_i,
  input  wire                out_valid_i,
  input  wire                out_ready_i,
  input  ptc_pkg::out_item_t out_data_i,
  input  wire                cfg_valid_i,
  input  wire                cfg_ready_i,
  input  wire  [1:0]         cfg_index_i,
  input  wire  [63:0]        cfg_data_i,
  output int                 fail_count_o,
  output int                 pending_o
);
  import ptc_pkg::*;

  logic [47:0] temp_coeffs;
  logic [63:0] press_low;
  logic [63:0] press_high;
  logic [15:0] press_nine;
  out_item_t   expected_q[$];

  function automatic logic [31:0] sra(input logic [31:0] x, input int n);
    logic [31:0] r;
    r = x >> n;
    if (x[31]) r = ~((~x) >> n);
    return r;
  endfunction

  function automatic logic [31:0] sext(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic out_item_t compensate(input in_item_t it);
    logic [31:0] ut, up, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [31:0] a, b, d, q, fine, p;
    out_item_t r;
    ut = {12'd0, it.raw_temperature};
    up = {12'd0, it.raw_pressure};
    t1 = {16'd0, temp_coeffs[15:0]};
    t2 = sext(temp_coeffs[31:16]);
    t3 = sext(temp_coeffs[47:32]);
    p1 = {16'd0, press_low[15:0]};
    p2 = sext(press_low[31:16]);
    p3 = sext(press_low[47:32]);
    p4 = sext(press_low[63:48]);
    p5 = sext(press_high[15:0]);
    p6 = sext(press_high[31:16]);
    p7 = sext(press_high[47:32]);
    p8 = sext(press_high[63:48]);
    p9 = sext(press_nine);
    a = sra(((ut >> 3) - (t1 << 1)) * t2, 11);
    d = (ut >> 4) - t1;
    b = sra(sra(d * d, 12) * t3, 14);
    fine = a + b;
    r.temperature_centi = sra(fine * 32'd5 + 32'd128, 8);
    a = sra(fine, 1) - 32'd64000;
    q = sra(a, 2);
    b = sra(q * q, 11) * p6;
    b = b + ((a * p5) << 1);
    b = sra(b, 2) + (p4 << 16);
    a = sra(sra(p3 * sra(q * q, 13), 3) + sra(p2 * a, 1), 18);
    a = sra((32'd32768 + a) * p1, 15);
    if (a == 0) begin
      r.pressure_pa = 0;
      r.pressure_invalid = 1'b1;
      return r;
    end
    p = ((32'd1048576 - up) - sra(b, 12)) * 32'd3125;
    // The division order depends on whether the dividend has its top bit set.
    if (!p[31]) p = (p << 1) / a;
    else p = (p / a) * 32'd2;
    q = ((p >> 3) * (p >> 3)) >> 13;
    a = sra(p9 * q, 12);
    b = sra((p >> 2) * p8, 13);
    r.pressure_pa = p + sra(a + b + p7, 4);
    r.pressure_invalid = 1'b0;
    return r;
  endfunction

  assign pending_o = expected_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t e;
    if (!rst_ni) begin
      temp_coeffs <= '0;
      press_low <= '0;
      press_high <= '0;
      press_nine <= '0;
      fail_count_o <= 0;
      expected_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CfgTemp: temp_coeffs <= cfg_data_i[47:0];
          CfgPressLow: press_low <= cfg_data_i;
          CfgPressHigh: press_high <= cfg_data_i;
          CfgPressNine: press_nine <= cfg_data_i[15:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) expected_q.push_back(compensate(in_data_i));
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, out_data_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          e = expected_q.pop_front();
          if (e !== out_data_i) begin
            $display("%0t: mismatch expected t=%0d p=%0d inv=%b actual t=%0d p=%0d inv=%b",
                     $time, e.temperature_centi, e.pressure_pa, e.pressure_invalid,
                     out_data_i.temperature_centi, out_data_i.pressure_pa,
                     out_data_i.pressure_invalid);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end
endmodule

@@ tb/pressure_temperature_compensation_core_tb.sv @@
// Stimulus and verdict for the compensation core. The checker beside the
// block predicts every result; this module feeds items and coefficients and drives the receiver's ready.
module pressure_temperature_compensation_core_tb;
  import ptc_pkg::*;

  localparam int LatencyCycles = 60;
  localparam int WatchdogLimit = 2000;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_ready;
  out_item_t   out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [63:0] cfg_data;
  int          fail_count;
  int          pending;
  int          idle_cycles;
  bit          calm;

  pressure_temperature_compensation_core uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_data_o(out_data),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  ptc_checker checker_i (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_ready_i(in_ready), .in_data_i(in_data),
    .out_valid_i(out_valid), .out_ready_i(out_ready), .out_data_i(out_data),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // The receiver stalls in random bursts, except in the calm tail of the run.
  initial begin
    int stall;
    out_ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!calm && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 13);
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready <= 1'b1;
    end
  end

  // Cycles without any handshake on input, output or configuration count toward the timeout.
  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Valid stays high after the accepting edge so that items can follow back
  // to back; an idle burst or the drain task drops it.
  task automatic send_item(input logic [19:0] ut, input logic [19:0] up);
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data <= '{raw_temperature: ut, raw_pressure: up};
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
  endtask

  task automatic write_coeff(input logic [1:0] idx, input logic [63:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    cfg_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Waits until every expected result is back, then lets the chain drain.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (LatencyCycles) @(posedge clk_i);
  endtask

  // Typical calibration, so most random items land on a meaningful pressure.
  task automatic write_typical();
    write_coeff(CfgTemp, {16'd0, 16'hFC18, 16'd26435, 16'd27504});
    write_coeff(CfgPressLow, {16'd2855, 16'hD0F4, 16'hD5D0, 16'd36477});
    write_coeff(CfgPressHigh, {16'hF448, 16'd15500, 16'hFFF9, 16'd140});
    write_coeff(CfgPressNine, 64'd6000);
  endtask

  task automatic write_random();
    write_coeff(CfgTemp, {$urandom, $urandom});
    write_coeff(CfgPressLow, {$urandom, $urandom});
    write_coeff(CfgPressHigh, {$urandom, $urandom});
    write_coeff(CfgPressNine, {$urandom, $urandom});
  endtask

  task automatic random_items(input int count);
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(0, 9) == 0)
        send_item(20'($urandom_range(0, 20'hFFFFF)), 20'($urandom_range(0, 20'hFFFFF)));
      else
        send_item(20'($urandom_range(400000, 600000)),
                  20'($urandom_range(250000, 450000)));
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = CfgTemp;
    cfg_data = '0;
    calm = 1'b0;
    idle_cycles = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset coefficients make the divisor zero, so every item is invalid.
    send_item(20'd0, 20'd0);
    send_item(20'hFFFFF, 20'hFFFFF);
    drain();

    // Directed items with a typical calibration: field extremes and midrange.
    write_typical();
    send_item(20'd0, 20'd0);
    send_item(20'hFFFFF, 20'hFFFFF);
    send_item(20'd0, 20'hFFFFF);
    send_item(20'hFFFFF, 20'd0);
    send_item(20'd519888, 20'd415148);
    send_item(20'hAAAAA, 20'h55555);
    send_item(20'h55555, 20'hAAAAA);
    // P1 of zero forces the zero divisor with a computed temperature.
    drain();
    write_coeff(CfgPressLow, {16'd2855, 16'hD0F4, 16'hD5D0, 16'd0});
    send_item(20'd519888, 20'd415148);
    drain();

    // Extreme coefficients: all ones and the signed limits.
    write_coeff(CfgTemp, 64'hFFFF_FFFF_FFFF_FFFF);
    write_coeff(CfgPressLow, 64'hFFFF_FFFF_FFFF_FFFF);
    write_coeff(CfgPressHigh, 64'hFFFF_FFFF_FFFF_FFFF);
    write_coeff(CfgPressNine, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(20'd0, 20'hFFFFF);
    send_item(20'hFFFFF, 20'd0);
    drain();
    write_coeff(CfgTemp, {16'd0, 16'h8000, 16'h8000, 16'hFFFF});
    write_coeff(CfgPressLow, {16'h7FFF, 16'h8000, 16'h7FFF, 16'hFFFF});
    write_coeff(CfgPressHigh, {16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF});
    write_coeff(CfgPressNine, 64'h7FFF);
    send_item(20'd0, 20'd0);
    send_item(20'hFFFFF, 20'hFFFFF);
    send_item(20'd123456, 20'd654321);
    drain();

    // Random part: typical and random calibrations in turn.
    for (int ph = 0; ph < 6; ph++) begin
      if (ph % 2 == 0) write_typical();
      else write_random();
      random_items(90);
      drain();
    end

    // Calm tail: no idling on either side.
    calm = 1'b1;
    write_typical();
    random_items(60);
    drain();

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

@@ sim.f @@
+incdir+design
design/ptc_pkg.sv
design/ptc_arith_cell.sv
design/ptc_div_cell.sv
design/pressure_temperature_compensation_core.sv
tb/ptc_checker.sv
tb/pressure_temperature_compensation_core_tb.sv
